// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes of the rational arithmetic unit
// Command and status codes, the sequencer states and the payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_EQ  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_PREP,
        S_GCD,
        S_DIV
    } state_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_equal;
        logic [1:0]         status;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add, subtract, multiply, divide and equality compare, with the
// result reduced to lowest terms by a binary GCD and two serial divisions.
// ----------------------------------------------------------------------------
// One item is worked at a time; in_stall stays high from the transfer until
// its result has been taken. Commands with a zero denominator or divisor and
// unused codes offer their result in the cycle after the transfer. A compare
// passes the sequencer as two products and the compare. Arithmetic forms
// two products (three for add and subtract) through one shared 33x33
// multiplier and a preparation step, which ends a zero numerator, then runs
// the binary GCD steps on 64-bit values and the two restoring divisions of
// 64 bits, one quotient bit per cycle.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire rau_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output rau_pkg::out_t      out_data
);
    import rau_pkg::*;

    localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    out_t   out_reg, out_next;

    logic [2:0]         cmd_reg, cmd_next;
    logic signed [31:0] an_reg, an_next, bn_reg, bn_next;
    logic [30:0]        ad_reg, ad_next, bd_reg, bd_next;
    logic [31:0]        am_reg, am_next, bm_reg, bm_next;
    logic               neg_reg, neg_next;
    logic [63:0]        p1_reg, p1_next, p2_reg, p2_next, p3_reg, p3_next;
    logic [63:0]        nmag_reg, nmag_next, den_reg, den_next;
    logic [63:0]        gx_reg, gx_next, gy_reg, gy_next, g_reg, g_next;
    logic [5:0]         gk_reg, gk_next;
    logic [63:0]        dq_reg, dq_next, rem_reg, rem_next, qn_reg, qn_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               phase_reg, phase_next;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic [63:0]        sum, smag, rsh, qd, qnum;
    logic               qbit, accept, is_arith;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign is_arith  = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        ma = {an_reg[31], an_reg};
        mb = {2'b00, bd_reg};
        unique case (state_reg)
            S_MUL0:
            begin
                if (cmd_reg == CMD_MUL)
                begin
                    ma = {1'b0, am_reg};
                    mb = {1'b0, bm_reg};
                end
                else if (cmd_reg == CMD_DIV)
                begin
                    ma = {1'b0, am_reg};
                end
            end
            S_MUL1:
            begin
                ma = {2'b00, ad_reg};
                if (cmd_reg == CMD_DIV)
                    mb = {1'b0, bm_reg};
                else if (cmd_reg != CMD_MUL)
                    ma = {bn_reg[31], bn_reg};
                if (is_arith || cmd_reg == CMD_EQ)
                    mb = {2'b00, ad_reg};
            end
            S_MUL2:
            begin
                ma = {2'b00, ad_reg};
            end
            default:
            begin
                ma = {an_reg[31], an_reg};
            end
        endcase
    end

    assign prod = ma * mb;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd_next   = cmd_reg;
        an_next    = an_reg;
        bn_next    = bn_reg;
        ad_next    = ad_reg;
        bd_next    = bd_reg;
        am_next    = am_reg;
        bm_next    = bm_reg;
        neg_next   = neg_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        p3_next    = p3_reg;
        nmag_next  = nmag_reg;
        den_next   = den_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        gk_next    = gk_reg;
        g_next     = g_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        qn_next    = qn_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        sum  = (cmd_reg == CMD_ADD) ? (p1_reg + p2_reg) : (p1_reg - p2_reg);
        smag = sum[63] ? (64'd0 - sum) : sum;
        rsh  = {rem_reg[62:0], dq_reg[63]};
        qbit = (rsh >= g_reg);
        qd   = {dq_reg[62:0], qbit};
        qnum = neg_reg ? (64'd0 - qn_reg) : qn_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = in_data.cmd;
                    an_next  = in_data.a_num;
                    bn_next  = in_data.b_num;
                    ad_next  = in_data.a_den;
                    bd_next  = in_data.b_den;
                    am_next  = in_data.a_num[31] ? (32'd0 - in_data.a_num) : in_data.a_num;
                    bm_next  = in_data.b_num[31] ? (32'd0 - in_data.b_num) : in_data.b_num;
                    neg_next = in_data.a_num[31] ^ in_data.b_num[31];
                    out_next = '{res_num: 32'sd0, res_den: 31'd1, is_equal: 1'b0,
                                 status: ST_OK};
                    if (in_data.cmd > CMD_EQ)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else if (in_data.a_den == 31'd0 || in_data.b_den == 31'd0 ||
                             (in_data.cmd == CMD_DIV && in_data.b_num == 32'sd0))
                    begin
                        out_next.status = ST_DIVZERO;
                        out_valid_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0:
            begin
                p1_next    = prod[63:0];
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                p2_next    = prod[63:0];
                state_next = is_arith ? S_MUL2 : S_PREP;
            end
            S_MUL2:
            begin
                p3_next    = prod[63:0];
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (cmd_reg == CMD_EQ)
                begin
                    out_next.is_equal = (p1_reg == p2_reg);
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    if (is_arith)
                    begin
                        nmag_next = smag;
                        den_next  = p3_reg;
                        neg_next  = sum[63];
                    end
                    else
                    begin
                        nmag_next = p1_reg;
                        den_next  = p2_reg;
                    end
                    gx_next = nmag_next;
                    gy_next = den_next;
                    gk_next = 6'd0;
                    if (nmag_next == 64'd0)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (gx_reg == gy_reg)
                begin
                    g_next     = gx_reg << gk_reg;
                    dq_next    = nmag_reg;
                    rem_next   = 64'd0;
                    cnt_next   = 6'd0;
                    phase_next = 1'b0;
                    state_next = S_DIV;
                end
                else if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                    gy_next = gy_reg >> 1;
                    gk_next = gk_reg + 6'd1;
                end
                else if (!gx_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                end
                else if (!gy_reg[0])
                begin
                    gy_next = gy_reg >> 1;
                end
                else if (gx_reg > gy_reg)
                begin
                    gx_next = gx_reg - gy_reg;
                end
                else
                begin
                    gy_next = gy_reg - gx_reg;
                end
            end
            S_DIV:
            begin
                rem_next = qbit ? (rsh - g_reg) : rsh;
                dq_next  = qd;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    if (!phase_reg)
                    begin
                        qn_next    = qd;
                        dq_next    = den_reg;
                        rem_next   = 64'd0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        // Numerator may reach one more in magnitude when negative.
                        if (qd > LIM || qn_reg > (LIM + {63'd0, neg_reg}))
                        begin
                            out_next.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            out_next.res_num = qnum[31:0];
                            out_next.res_den = qd[30:0];
                        end
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        cmd_reg   <= cmd_next;
        an_reg    <= an_next;
        bn_reg    <= bn_next;
        ad_reg    <= ad_next;
        bd_reg    <= bd_next;
        am_reg    <= am_next;
        bm_reg    <= bm_next;
        neg_reg   <= neg_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        p3_reg    <= p3_next;
        nmag_reg  <= nmag_next;
        den_reg   <= den_next;
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        gk_reg    <= gk_next;
        g_reg     <= g_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        qn_reg    <= qn_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
    end

    // A pending result or a busy sequencer must hold off the next transfer.
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE || out_valid_reg) |-> in_stall)
        else $error("input accepted while busy");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |->
        (out_data.res_num == 32'sd0 && out_data.res_den == 31'd1 && !out_data.is_equal))
        else $error("error result carries a value");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.res_den != 31'd0))
        else $error("zero denominator delivered");

    a_no_result_midway: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD || state_reg == S_MUL0) |=> !$rose(out_valid_reg))
        else $error("result raised outside a finishing step");

endmodule

`default_nettype wire
